>>> sv/lmb_pkg.sv
// ----------------------------------------------------------------------------
// lmb_pkg: shared types and constants for the 3x3 local-mean binarizer
// Pixel and coordinate widths, register codes, the job passed through the
// queue between front and back, and the effective-size helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lmb_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COORD_BITS     = 12;
  localparam int REG_BITS       = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int WIN_TAPS       = 9;
  localparam int SUM_BITS       = PIXEL_BITS + 4;
  localparam int N_SUB          = 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int ROW_ADDR_BITS  = $clog2(MAX_WIDTH);

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIXEL_BITS-1:0]    pix_t;
  typedef pix_t [WIN_TAPS-1:0]      window_t;   // index row*3+col, col 2 newest
  typedef logic [COORD_BITS-1:0]    coord_t;

  // One queued pixel: its window and the sub-results it releases.
  // Mask bit order: normal/normal, normal/late col, late row/normal, late/late.
  typedef struct packed {
    window_t            window;
    coord_t             row;
    coord_t             col;
    logic [N_SUB-1:0]   mask;
  } job_t;

  typedef struct packed {
    logic [QCOUNT_BITS-1:0] count;
    logic                   empty;
  } q_stat_t;

  typedef struct packed {
    logic   valid;
    coord_t row;
    coord_t col;
    logic   hit;
    logic   last;
  } res_t;

  // Last valid index for a size register: zero acts as one, oversize saturates.
  function automatic coord_t last_index(input logic [REG_BITS-1:0] v,
                                        input logic [REG_BITS-1:0] lim);
    logic [REG_BITS-1:0] m;
    begin
      m = v - 1'b1;
      if (v == '0) begin
        last_index = '0;
      end else if (v > lim) begin
        m = lim - 1'b1;
        last_index = m[COORD_BITS-1:0];
      end else begin
        last_index = m[COORD_BITS-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/local_mean_binarize_3x3_top.sv
// ----------------------------------------------------------------------------
// local_mean_binarize_3x3_top: streaming 3x3 local-mean binarizer
// Raster pixels in, one thresholded bit per pixel out with its position.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while full is low; results leave at one
//   per cycle while pop is held. Results pass the row-store read stage,
//   the job queue and the result register, and wait when results queue.
// The bottom row and right column release up to four results per pixel, so
//   full rises there while the four-entry job queue drains.
// Reset: synchronous; size registers go to 4096, position and window clear.
//   The row stores are not cleared and need no pass after reset.
`default_nettype none

module local_mean_binarize_3x3_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lmb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lmb_pkg::REG_BITS-1:0]       cfg_data,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [lmb_pkg::PIXEL_BITS-1:0]     pixel,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [11:0]                             out_row,
  output logic [11:0]                             out_col,
  output logic                                    binary_bit,
  output logic                                    last_of_run
);

  // Front to queue: one job per pixel that completes any neighbourhood.
  logic             q_push;
  lmb_pkg::job_t    q_job;
  // Queue to back: head job and fill state shared with the front.
  lmb_pkg::job_t    q_head;
  lmb_pkg::q_stat_t q_stat;
  logic             q_pop;
  lmb_pkg::res_t    res;

  // Intake: position tracking, row stores, window shift, classification.
  lmb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .pixel    (pixel),
    .full     (full),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Decouple intake from evaluation so either side may stall alone.
  lmb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_job),
    .pop     (q_pop),
    .head    (q_head),
    .stat    (q_stat)
  );

  // Evaluation: one neighbourhood per cycle into the result register when free.
  lmb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .q_stat(q_stat),
    .q_pop (q_pop),
    .pop   (pop),
    .res   (res)
  );

  assign empty       = !res.valid;
  assign out_row     = res.row;
  assign out_col     = res.col;
  assign binary_bit  = res.hit;
  assign last_of_run = res.last;

  // The in-flight reservation must keep the queue from overflowing.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_stat.count < lmb_pkg::QCOUNT_BITS'(lmb_pkg::QUEUE_DEPTH)))
    else $error("job queue pushed while full");

  // The back may only retire a job that is present.
  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("job queue popped while empty");

  // A retired job leaves the back with no partial progress behind.
  a_back_retire: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !empty && last_of_run)
    else $error("retired job did not end on a last-of-run result");

endmodule

`default_nettype wire

>>> sv/lmb_ram.sv
// ----------------------------------------------------------------------------
// lmb_ram: generic simple dual-port RAM
// One write port, one read port with registered data; a read at the address
// being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/lmb_front.sv
// ----------------------------------------------------------------------------
// lmb_front: pixel intake, row stores and window
// Tracks the frame position, reads and rewrites the two row stores, shifts
// the 3x3 window and hands each pixel that releases results to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lmb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lmb_pkg::REG_BITS-1:0]       cfg_data,
  input  wire logic                               push,
  input  wire lmb_pkg::pix_t                      pixel,
  output logic                                    full,
  input  wire lmb_pkg::q_stat_t                   q_stat,
  output logic                                    q_push,
  output lmb_pkg::job_t                           q_job
);

  logic [lmb_pkg::REG_BITS-1:0] image_width;
  logic [lmb_pkg::REG_BITS-1:0] image_height;
  lmb_pkg::coord_t              col_count;
  lmb_pkg::coord_t              row_count;
  lmb_pkg::coord_t              last_col;
  lmb_pkg::coord_t              last_row;
  logic                         accept;

  logic                         s1_valid;
  lmb_pkg::pix_t                s1_pixel;
  lmb_pkg::coord_t              s1_row;
  lmb_pkg::coord_t              s1_col;

  logic                         fwd_valid;
  lmb_pkg::coord_t              fwd_addr;
  lmb_pkg::pix_t                fwd_older;
  lmb_pkg::pix_t                fwd_newer;
  logic                         fwd_hit;

  lmb_pkg::pix_t                older_q;
  lmb_pkg::pix_t                newer_q;
  lmb_pkg::pix_t                older_rd;
  lmb_pkg::pix_t                newer_rd;
  lmb_pkg::pix_t                above2;
  lmb_pkg::pix_t                above1;

  lmb_pkg::window_t             window;
  lmb_pkg::window_t             window_next;
  logic [lmb_pkg::N_SUB-1:0]    mask;
  logic [lmb_pkg::QCOUNT_BITS:0] pending;

  assign last_col = lmb_pkg::last_index(image_width,
                                        lmb_pkg::REG_BITS'(lmb_pkg::MAX_WIDTH));
  assign last_row = lmb_pkg::last_index(image_height,
                                        lmb_pkg::REG_BITS'(lmb_pkg::MAX_HEIGHT));

  // Reserve a queue slot for the pixel still in flight.
  assign pending = (lmb_pkg::QCOUNT_BITS+1)'(q_stat.count)
                 + (lmb_pkg::QCOUNT_BITS+1)'(s1_valid);
  assign full    = rst || (pending >= (lmb_pkg::QCOUNT_BITS+1)'(lmb_pkg::QUEUE_DEPTH));
  assign accept  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lmb_pkg::REG_BITS'(lmb_pkg::MAX_WIDTH);
      image_height <= lmb_pkg::REG_BITS'(lmb_pkg::MAX_HEIGHT);
      col_count    <= '0;
      row_count    <= '0;
    end else if (cfg_we && (cfg_index == lmb_pkg::REG_IMAGE_WIDTH ||
                            cfg_index == lmb_pkg::REG_IMAGE_HEIGHT)) begin
      if (cfg_index == lmb_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_count == last_col) begin
        col_count <= '0;
        row_count <= (row_count == last_row) ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= s1_valid;
    end
    s1_pixel  <= pixel;
    s1_row    <= row_count;
    s1_col    <= col_count;
    fwd_addr  <= s1_col;
    fwd_older <= newer_rd;
    fwd_newer <= s1_pixel;
  end

  lmb_ram #(
    .WIDTH(lmb_pkg::PIXEL_BITS),
    .DEPTH(lmb_pkg::MAX_WIDTH)
  ) u_older_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col[lmb_pkg::ROW_ADDR_BITS-1:0]),
    .wdata(newer_rd),
    .raddr(col_count[lmb_pkg::ROW_ADDR_BITS-1:0]),
    .rdata(older_q)
  );

  lmb_ram #(
    .WIDTH(lmb_pkg::PIXEL_BITS),
    .DEPTH(lmb_pkg::MAX_WIDTH)
  ) u_newer_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col[lmb_pkg::ROW_ADDR_BITS-1:0]),
    .wdata(s1_pixel),
    .raddr(col_count[lmb_pkg::ROW_ADDR_BITS-1:0]),
    .rdata(newer_q)
  );

  // Single-column frames take the entry that the previous pixel has just written.
  assign fwd_hit  = fwd_valid && (fwd_addr == s1_col);
  assign older_rd = fwd_hit ? fwd_older : older_q;
  assign newer_rd = fwd_hit ? fwd_newer : newer_q;

  always_comb begin
    if (s1_row == '0) begin
      above2 = s1_pixel;
      above1 = s1_pixel;
    end else if (s1_row == lmb_pkg::COORD_BITS'(1)) begin
      above2 = newer_rd;
      above1 = newer_rd;
    end else begin
      above2 = older_rd;
      above1 = newer_rd;
    end
  end

  always_comb begin
    window_next = window;
    if (s1_col == '0) begin
      for (int k = 0; k < 3; k++) begin
        window_next[k]     = above2;
        window_next[3 + k] = above1;
        window_next[6 + k] = s1_pixel;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        window_next[i*3 + 0] = window[i*3 + 1];
        window_next[i*3 + 1] = window[i*3 + 2];
      end
      window_next[2] = above2;
      window_next[5] = above1;
      window_next[8] = s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid) begin
      window <= window_next;
    end
  end

  // Classify: which of the four neighbourhoods this pixel completes.
  always_comb begin
    mask[0] = (s1_row != '0)     && (s1_col != '0);
    mask[1] = (s1_row != '0)     && (s1_col == last_col);
    mask[2] = (s1_row == last_row) && (s1_col != '0);
    mask[3] = (s1_row == last_row) && (s1_col == last_col);
  end

  assign q_push       = s1_valid && (mask != '0);
  assign q_job.window = window_next;
  assign q_job.row    = s1_row;
  assign q_job.col    = s1_col;
  assign q_job.mask   = mask;

endmodule

`default_nettype wire

>>> sv/lmb_queue.sv
// ----------------------------------------------------------------------------
// lmb_queue: short job queue between front and back
// A small circular buffer of jobs; the front never pushes into a full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lmb_pkg::job_t    push_job,
  input  wire logic             pop,
  output lmb_pkg::job_t         head,
  output lmb_pkg::q_stat_t      stat
);

  lmb_pkg::job_t                   slots [lmb_pkg::QUEUE_DEPTH];
  logic [lmb_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [lmb_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [lmb_pkg::QCOUNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= lmb_pkg::QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= lmb_pkg::QPTR_BITS'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

>>> sv/lmb_back.sv
// ----------------------------------------------------------------------------
// lmb_back: threshold evaluation and result register
// Walks the pending neighbourhoods of the head job, one per cycle while the
// result register is free or popped, and holds each result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lmb_pkg::job_t    head,
  input  wire lmb_pkg::q_stat_t q_stat,
  output logic                  q_pop,
  input  wire logic             pop,
  output lmb_pkg::res_t         res
);

  logic [lmb_pkg::N_SUB-1:0]  done;
  logic [lmb_pkg::N_SUB-1:0]  pend;
  logic [lmb_pkg::N_SUB-1:0]  sel_mask;
  logic [1:0]                 sel;
  logic                       rlate;
  logic                       clate;
  logic                       last;
  logic                       load;
  logic [1:0]                 rs [3];
  logic [1:0]                 cs [3];
  logic [lmb_pkg::SUM_BITS-1:0] sum;
  logic [lmb_pkg::SUM_BITS-1:0] nine_c;
  lmb_pkg::pix_t              centre;
  lmb_pkg::coord_t            ro;
  lmb_pkg::coord_t            co;

  assign pend = head.mask & ~done;

  always_comb begin
    sel = 2'd3;
    for (int i = lmb_pkg::N_SUB - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign sel_mask = lmb_pkg::N_SUB'(1) << sel;
  assign last     = ((pend & ~sel_mask) == '0);
  assign rlate    = sel[1];
  assign clate    = sel[0];
  assign load     = !q_stat.empty && (!res.valid || pop);
  assign q_pop    = load && last;

  // Late neighbourhoods replicate the bottom row or right column.
  always_comb begin
    rs[0] = rlate ? 2'd1 : 2'd0;
    rs[1] = rlate ? 2'd2 : 2'd1;
    rs[2] = 2'd2;
    cs[0] = clate ? 2'd1 : 2'd0;
    cs[1] = clate ? 2'd2 : 2'd1;
    cs[2] = 2'd2;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + lmb_pkg::SUM_BITS'(head.window[4'(rs[i]) * 4'd3 + 4'(cs[j])]);
      end
    end
    centre = head.window[4'(rs[1]) * 4'd3 + 4'(cs[1])];
    nine_c = (lmb_pkg::SUM_BITS'(centre) << 3) + lmb_pkg::SUM_BITS'(centre);
  end

  assign ro = rlate ? head.row : head.row - 1'b1;
  assign co = clate ? head.col : head.col - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      res.valid <= 1'b0;
    end else begin
      if (load) begin
        done      <= last ? '0 : (done | sel_mask);
        res.valid <= 1'b1;
      end else if (pop) begin
        res.valid <= 1'b0;
      end
    end
    if (load) begin
      res.row  <= ro;
      res.col  <= co;
      res.hit  <= (nine_c <= sum);
      res.last <= last;
    end
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for local_mean_binarize_3x3_top
// Streams raster pixels through frames of many sizes, predicts every
// thresholded bit with its position and run-end flag, and compares each
// item popped from the block against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 345;
  localparam int SETTLE_CYCLES  = 10;     // pipeline depth plus margin
  localparam int TAIL_CYCLES    = 20;
  localparam int STALL_LIMIT    = 2000;   // cycles with no handshake at all
  localparam int IDLE_PERCENT   = 16;
  localparam int REG_TOP        = (1 << lmb_pkg::REG_BITS) - 1;
  localparam int FIRST_SPARE    = 2;      // indexes above the size registers
  localparam int LAST_SPARE     = (1 << lmb_pkg::CFG_INDEX_BITS) - 1;

  typedef enum {PIX_UNIFORM, PIX_BINARY, PIX_NEAR_FLAT, PIX_FLAT} pix_style_e;

  // One thresholded pixel as it leaves the block.
  typedef struct {
    lmb_pkg::coord_t row;
    lmb_pkg::coord_t col;
    logic            hit;
    logic            last;
  } bit_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [lmb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [lmb_pkg::REG_BITS-1:0]       cfg_data = '0;
  logic                               push = 1'b0;
  logic                               full;
  logic [lmb_pkg::PIXEL_BITS-1:0]     pixel = '0;
  logic                               empty;
  logic                               pop = 1'b0;
  logic [11:0]                        out_row;
  logic [11:0]                        out_col;
  logic                               binary_bit;
  logic                               last_of_run;

  // Items waiting to be pushed, and thresholded bits still owed by the block.
  logic [lmb_pkg::PIXEL_BITS-1:0] pixels_to_send [$];
  bit_result_t                    bits_due [$];

  // Shadow of the binarizer: size registers, row stores, window, position.
  logic [lmb_pkg::REG_BITS-1:0]   img_width;
  logic [lmb_pkg::REG_BITS-1:0]   img_height;
  logic [lmb_pkg::PIXEL_BITS-1:0] older_row [lmb_pkg::MAX_WIDTH];
  logic [lmb_pkg::PIXEL_BITS-1:0] newer_row [lmb_pkg::MAX_WIDTH];
  logic [lmb_pkg::PIXEL_BITS-1:0] win [lmb_pkg::WIN_TAPS];     // row*3+col, col 2 newest
  int unsigned                    row_pos;
  int unsigned                    col_pos;

  int  pixels_taken = 0;
  int  mismatches = 0;
  int  stall_cycles = 0;
  logic calm;

  // A stretch of about a hundred items where neither side idles.
  assign calm = (pixels_taken >= 120) && (pixels_taken < 220);

  local_mean_binarize_3x3_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .pixel       (pixel),
    .empty       (empty),
    .pop         (pop),
    .out_row     (out_row),
    .out_col     (out_col),
    .binary_bit  (binary_bit),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Size actually in force: zero acts as one, oversize saturates.
  function automatic int unsigned size_in_force(input int unsigned v, input int unsigned lim);
    if (v == 0) size_in_force = 1;
    else if (v > lim) size_in_force = lim;
    else size_in_force = v;
  endfunction

  // Mostly small sizes; now and then zero, the maximum, oversize or medium.
  function automatic int unsigned pick_size(input int unsigned lim, input int unsigned common_hi);
    case ($urandom_range(11))
      0: pick_size = 0;
      1: pick_size = lim;
      2: pick_size = $urandom_range(lim + 1, REG_TOP);
      3: pick_size = $urandom_range(9, 40);
      default: pick_size = $urandom_range(1, common_hi);
    endcase
  endfunction

  // Threshold the window: late row/col picks taps 1,2,2 in place of 0,1,2,
  // which is how edge replication looks on the bottom row and right column.
  function automatic logic window_hit(input bit rlate, input bit clate);
    int unsigned rs [3];
    int unsigned cs [3];
    int unsigned sum;
    int unsigned centre;
    rs[0] = rlate ? 1 : 0; rs[1] = rlate ? 2 : 1; rs[2] = 2;
    cs[0] = clate ? 1 : 0; cs[1] = clate ? 2 : 1; cs[2] = 2;
    sum = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        sum += win[rs[i] * 3 + cs[j]];
    centre = win[rs[1] * 3 + cs[1]];
    window_hit = (9 * centre <= sum);
  endfunction

  // Take one pixel into the shadow and queue every bit it completes.
  task automatic threshold_pixel(input logic [lmb_pkg::PIXEL_BITS-1:0] p);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic [lmb_pkg::PIXEL_BITS-1:0] above2;
    logic [lmb_pkg::PIXEL_BITS-1:0] above1;
    bit_result_t batch [$];
    bit_result_t one;
    w = size_in_force(img_width, lmb_pkg::MAX_WIDTH);
    h = size_in_force(img_height, lmb_pkg::MAX_HEIGHT);
    r = (row_pos >= h) ? h - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;

    // Replicate the top border; row 1 reuses the row above for both taps.
    if (r == 0) begin
      above2 = p;
      above1 = p;
    end else if (r == 1) begin
      above1 = newer_row[c];
      above2 = above1;
    end else begin
      above2 = older_row[c];
      above1 = newer_row[c];
    end
    older_row[c] = newer_row[c];
    newer_row[c] = p;

    // Fill the window on column 0 (left border), else shift it left.
    if (c == 0) begin
      for (int k = 0; k < 3; k++) begin
        win[k]     = above2;
        win[3 + k] = above1;
        win[6 + k] = p;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        win[i * 3]     = win[i * 3 + 1];
        win[i * 3 + 1] = win[i * 3 + 2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = p;
    end

    // Release the pixel up-left, plus the late ones on the bottom row and
    // right column: up to four at the last pixel of a frame.
    for (int i = 0; i < 2; i++)
      for (int k = 0; k < 2; k++) begin
        if (i == 0 && r == 0) continue;
        if (i == 1 && r != h - 1) continue;
        if (k == 0 && c == 0) continue;
        if (k == 1 && c != w - 1) continue;
        one.row  = lmb_pkg::coord_t'((i == 1) ? r : r - 1);
        one.col  = lmb_pkg::coord_t'((k == 1) ? c : c - 1);
        one.hit  = window_hit(i == 1, k == 1);
        one.last = 1'b0;
        batch.push_back(one);
      end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[j]) bits_due.push_back(batch[j]);

    // Advance the raster position, wrapping at the end of the frame.
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Write one register at the next falling edge; hold the enable one cycle.
  task automatic write_reg(input logic [lmb_pkg::CFG_INDEX_BITS-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[lmb_pkg::REG_BITS-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_index <= lmb_pkg::CFG_INDEX_BITS'($urandom_range(LAST_SPARE));
    cfg_data  <= lmb_pkg::REG_BITS'($urandom_range(REG_TOP));
  endtask

  // Wait for every item to go in and every bit to come out, then let
  // row-0 pixels that release nothing clear the pipeline.
  task automatic wait_drained();
    while (pixels_to_send.size() > 0 || bits_due.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: change inputs on the falling edge; idle now and then on each side.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (pixels_to_send.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        push  <= 1'b1;
        pixel <= pixels_to_send[0];
      end else begin
        push  <= 1'b0;
        pixel <= lmb_pkg::PIXEL_BITS'($urandom_range(255));
      end
      pop <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Monitor: sample handshakes on the rising edge, keep the shadow in step,
  // check popped items and guard against a hang.
  always @(posedge clk) begin
    if (rst) begin
      img_width  = lmb_pkg::REG_BITS'(lmb_pkg::MAX_WIDTH);
      img_height = lmb_pkg::REG_BITS'(lmb_pkg::MAX_HEIGHT);
      foreach (win[k]) win[k] = '0;
      row_pos = 0;
      col_pos = 0;
      stall_cycles = 0;
    end else begin
      // Any size write restarts the frame; spare indexes do nothing.
      if (cfg_we) begin
        if (cfg_index == lmb_pkg::REG_IMAGE_WIDTH) begin
          img_width = cfg_data;
          row_pos = 0;
          col_pos = 0;
        end else if (cfg_index == lmb_pkg::REG_IMAGE_HEIGHT) begin
          img_height = cfg_data;
          row_pos = 0;
          col_pos = 0;
        end
      end

      if (pop && !empty) begin
        if (bits_due.size() == 0) begin
          $display("%0t: result with nothing due, row %0d col %0d bit %0d last %0d",
                   $time, out_row, out_col, binary_bit, last_of_run);
          mismatches++;
        end else begin
          check_field("out_row", bits_due[0].row, out_row);
          check_field("out_col", bits_due[0].col, out_col);
          check_field("binary_bit", bits_due[0].hit, binary_bit);
          check_field("last_of_run", bits_due[0].last, last_of_run);
          void'(bits_due.pop_front());
        end
      end

      if (push && !full) begin
        threshold_pixel(pixel);
        void'(pixels_to_send.pop_front());
        pixels_taken++;
      end

      if (cfg_we || (pop && !empty) || (push && !full)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus: directed frames first, then random frames of random sizes.
  initial begin
    int unsigned w_val;
    int unsigned h_val;
    int unsigned ew;
    int unsigned eh;
    int unsigned area;
    int unsigned n_pix;
    int unsigned split;
    int          queued;
    int          phase;
    logic [lmb_pkg::PIXEL_BITS-1:0] base;
    logic [lmb_pkg::PIXEL_BITS-1:0] px;
    pix_style_e  style;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset sizes: a few row-0 pixels of a 4096x4096 frame release nothing.
    pixels_to_send.push_back(8'h00); pixels_to_send.push_back(8'hFF);
    pixels_to_send.push_back(8'h80);
    wait_drained();

    // Zero sizes act as one: every pixel is its own frame, all four borders.
    write_reg(lmb_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(lmb_pkg::REG_IMAGE_HEIGHT, 0);
    pixels_to_send.push_back(8'h00); pixels_to_send.push_back(8'hFF);
    pixels_to_send.push_back(8'h5A);
    wait_drained();

    // 2x2: the last pixel releases four bits at once.
    write_reg(lmb_pkg::REG_IMAGE_WIDTH, 2);
    write_reg(lmb_pkg::REG_IMAGE_HEIGHT, 2);
    pixels_to_send.push_back(8'hFF); pixels_to_send.push_back(8'h00);
    pixels_to_send.push_back(8'h00); pixels_to_send.push_back(8'hFF);
    wait_drained();

    // 3x3 checkerboard of extremes with a near-dark corner.
    write_reg(lmb_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(lmb_pkg::REG_IMAGE_HEIGHT, 3);
    pixels_to_send.push_back(8'hFF); pixels_to_send.push_back(8'h00);
    pixels_to_send.push_back(8'hFF); pixels_to_send.push_back(8'h00);
    pixels_to_send.push_back(8'hFF); pixels_to_send.push_back(8'h00);
    pixels_to_send.push_back(8'hFF); pixels_to_send.push_back(8'h00);
    pixels_to_send.push_back(8'h01);
    wait_drained();

    // Oversize width saturates; one row so bits come out at once. Stop
    // mid-row so the next write restarts the frame.
    write_reg(lmb_pkg::REG_IMAGE_WIDTH, REG_TOP);
    write_reg(lmb_pkg::REG_IMAGE_HEIGHT, 1);
    pixels_to_send.push_back(8'h7F); pixels_to_send.push_back(8'h80);
    pixels_to_send.push_back(8'h55); pixels_to_send.push_back(8'hAA);
    pixels_to_send.push_back(8'h01); pixels_to_send.push_back(8'hFE);
    wait_drained();

    queued = DIRECTED_ITEMS;
    phase = 0;
    while (queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      w_val = pick_size(lmb_pkg::MAX_WIDTH, 8);
      h_val = pick_size(lmb_pkg::MAX_HEIGHT, 6);
      ew = size_in_force(w_val, lmb_pkg::MAX_WIDTH);
      // Wide rows: often a single-row frame so bits still come out.
      if (ew > 64 && $urandom_range(1)) h_val = $urandom_range(1);
      eh = size_in_force(h_val, lmb_pkg::MAX_HEIGHT);
      area = ew * eh;
      // Small frames: whole frames, sometimes with a partial one to restart.
      if (area <= 48) begin
        n_pix = area * $urandom_range(1, 3);
        if ($urandom_range(1)) n_pix += $urandom_range(0, area - 1);
      end else begin
        n_pix = $urandom_range(8, (area < 120) ? area : 120);
      end
      // Stop at the planned item count.
      if (n_pix > DIRECTED_ITEMS + RANDOM_ITEMS - queued)
        n_pix = unsigned'(DIRECTED_ITEMS + RANDOM_ITEMS - queued);

      if ($urandom_range(3) == 0)
        write_reg(lmb_pkg::CFG_INDEX_BITS'($urandom_range(FIRST_SPARE, LAST_SPARE)),
                  $urandom_range(REG_TOP));
      if ($urandom_range(1)) begin
        write_reg(lmb_pkg::REG_IMAGE_WIDTH, w_val);
        write_reg(lmb_pkg::REG_IMAGE_HEIGHT, h_val);
      end else begin
        write_reg(lmb_pkg::REG_IMAGE_HEIGHT, h_val);
        write_reg(lmb_pkg::REG_IMAGE_WIDTH, w_val);
      end

      style = pix_style_e'($urandom_range(3));
      base  = lmb_pkg::PIXEL_BITS'($urandom_range(252));
      // Sometimes hold the sender mid-frame until every owed bit is out.
      split = (phase == 0 || $urandom_range(3) == 0) ? n_pix / 2 : n_pix;
      for (int i = 0; i < n_pix; i++) begin
        if (i == split && i != 0)
          while (pixels_to_send.size() > 0 || bits_due.size() > 0) @(negedge clk);
        case (style)
          PIX_UNIFORM:   px = lmb_pkg::PIXEL_BITS'($urandom_range(255));
          PIX_BINARY:    px = $urandom_range(1) ? 8'hFF : 8'h00;
          PIX_NEAR_FLAT: px = base + lmb_pkg::PIXEL_BITS'($urandom_range(3));
          default:       px = ($urandom_range(9) == 0) ?
                              lmb_pkg::PIXEL_BITS'($urandom_range(255)) : base;
        endcase
        pixels_to_send.push_back(px);
      end
      queued += n_pix;
      wait_drained();
      phase++;
    end

    while (pixels_to_send.size() > 0 || bits_due.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lmb_pkg.sv
sv/lmb_ram.sv
sv/lmb_front.sv
sv/lmb_queue.sv
sv/lmb_back.sv
sv/local_mean_binarize_3x3_top.sv
verif/testbench.sv
